@@ rtl/hanging_plotter_segment_planner_unit_assert.svh @@
// assertion macros for the segment planner
`ifndef HANGING_PLOTTER_SEGMENT_PLANNER_UNIT_ASSERT_SVH
`define HANGING_PLOTTER_SEGMENT_PLANNER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HPSP_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define HPSP_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define HPSP_ASSERT(label, clk, rstn, prop)
`define HPSP_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ rtl/hpsp_pkg.sv @@
// types and constants of the segment planner
`default_nettype none
package hpsp_pkg;
  localparam int unsigned CoordFull = 65535;
  localparam logic [30:0] LenMax = 31'h7fffffff;
  localparam logic [31:0] IntervalMax = 32'hffffffff;

  typedef enum logic [2:0] {
    RegSpan = 3'd0, RegLeft = 3'd1, RegTop = 3'd2, RegHeight = 3'd3,
    RegExtent = 3'd4, RegSteps = 3'd5, RegBase = 3'd6, RegNone = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
  } in_beat_t;

  typedef struct packed {
    logic [30:0] left_steps;
    logic        left_pull;
    logic [30:0] right_steps;
    logic        right_pull;
    logic [31:0] left_interval_us;
    logic [31:0] right_interval_us;
    logic [30:0] new_left_length;
    logic [30:0] new_right_length;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } unit_ctl_t;
endpackage
`default_nettype wire

@@ rtl/hanging_plotter_segment_planner_unit.sv @@
// segment planner top level: registers, sequencer and shared serial units
// the serial multiplier, square root and divider are shared by both belts
// one beat is planned at a time; a new beat is taken while a result waits
// reset: registers to defaults, belt lengths to zero, sequencer idle, no result held
`default_nettype none
`include "hanging_plotter_segment_planner_unit_assert.svh"
module hanging_plotter_segment_planner_unit import hpsp_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_beat_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_beat_t        out_data_o
);
  localparam int unsigned F = FRACTION_BITS;
  localparam int unsigned PW = 16 + F + 2;      // signed offset width
  localparam int unsigned MW = PW - 1;          // magnitude width
  localparam int unsigned RW = MW + 1;          // sqrt result width
  localparam int unsigned SH = F + 16;
  localparam int unsigned MBW = (RW > 32) ? RW : 32;

  typedef enum logic [12:0] {
    StIdle = 13'h0001, StScX = 13'h0002, StScXw = 13'h0004, StScY = 13'h0008,
    StScYw = 13'h0010, StOff = 13'h0020, StSqH = 13'h0040, StSqV = 13'h0080,
    StRoot = 13'h0100, StLen = 13'h0200, StDiff = 13'h0400, StDiv = 13'h0800,
    StOut = 13'h1000
  } state_e;

  state_e st_q;
  logic [15:0] span_q, left_q, top_q, height_q, extent_q, base_q;
  logic [31:0] spm_q;
  logic [30:0] len_l_q, len_r_q, nl_q, nr_q;
  in_beat_t in_q;
  logic [F+15:0] px_q, py_q;
  logic [PW-1:0] v_q;
  logic side_q, sqphase_q;
  logic [2*RW-1:0] hh_q, sq_n;
  logic out_valid_q;
  out_beat_t out_q, res_q;
  reg_idx_e widx, ridx;

  // shared units
  logic mul_start, mul_done, sq_start, sq_done, dv_start, dv_done;
  logic [63:0] mul_a;
  logic [MBW-1:0] mul_b;
  logic [63+MBW:0] mul_p;
  logic [RW-1:0] sq_r;
  logic [63:0] dv_n, dv_q;
  logic [31:0] dv_d;
  unit_ctl_t ctl;

  hpsp_serial_mul #(.AW(64), .BW(MBW)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );
  hpsp_serial_sqrt #(.RW(RW)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .n_i(sq_n), .done_o(sq_done), .r_o(sq_r)
  );
  hpsp_serial_div #(.NW(64), .DW(32)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .n_i(dv_n), .d_i(dv_d),
    .done_o(dv_done), .q_o(dv_q)
  );

  assign pready = 1'b1;
  assign widx = reg_idx_e'(paddr[4:2]);
  assign ridx = reg_idx_e'(paddr[4:2]);
  always_comb begin
    case (ridx)
      RegSpan:   prdata = {16'd0, span_q};
      RegLeft:   prdata = {16'd0, left_q};
      RegTop:    prdata = {16'd0, top_q};
      RegHeight: prdata = {16'd0, height_q};
      RegExtent: prdata = {16'd0, extent_q};
      RegSteps:  prdata = spm_q;
      RegBase:   prdata = {16'd0, base_q};
      default:   prdata = '0;
    endcase
  end

  // step arithmetic
  logic [31:0] dl, dr, ls, rs, more, fewer;
  logic l_more;
  always_comb begin
    dl = {1'b0, nl_q} - {1'b0, len_l_q};
    dr = {1'b0, nr_q} - {1'b0, len_r_q};
    ls = dl[31] ? -dl : dl;
    rs = dr[31] ? -dr : dr;
    l_more = ls > rs;
    more = l_more ? ls : rs;
    fewer = l_more ? rs : ls;
  end

  // length from root times steps per mm
  logic [30:0] len_sat;
  always_comb begin
    if (mul_p[63+MBW:SH] > (64+MBW-SH)'(LenMax)) len_sat = LenMax;
    else len_sat = mul_p[SH+30:SH];
  end

  // offsets
  logic [PW-1:0] hl, hr, vv, hsel;
  logic [F+15:0] px_n;
  always_comb begin
    hl = PW'({left_q, F'(0)}) + PW'(px_q);
    hr = PW'({span_q, F'(0)}) - PW'({left_q, F'(0)}) - PW'(px_q);
    vv = PW'({top_q, F'(0)}) + PW'({height_q, F'(0)}) - PW'(py_q);
    hsel = side_q ? hr : hl;
    px_n = (F+16)'(dv_q);
  end

  logic [MW-1:0] hmag, vmag;
  assign hmag = hsel[PW-1] ? MW'(-hsel) : MW'(hsel);
  assign vmag = v_q[PW-1] ? MW'(-v_q) : MW'(v_q);

  // sum of squares, v^2 straight from the multiplier
  assign sq_n = hh_q + (2*RW)'(mul_p);

  always_comb begin
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    sq_start = 1'b0;
    dv_start = 1'b0;
    dv_n = '0;
    dv_d = 32'(CoordFull);
    case (st_q)
      StScX: begin
        mul_start = 1'b1;
        mul_a = 64'(in_q.x_pos);
        mul_b = MBW'(extent_q);
      end
      StScY: begin
        mul_start = 1'b1;
        mul_a = 64'(in_q.y_pos);
        mul_b = MBW'(extent_q);
      end
      StOff: begin
        mul_start = 1'b1;
        mul_a = 64'(hmag);
        mul_b = MBW'(hmag);
      end
      StSqH: if (mul_done) begin
        mul_start = 1'b1;
        mul_a = 64'(vmag);
        mul_b = MBW'(vmag);
      end
      StSqV: if (mul_done) sq_start = 1'b1;
      StRoot: if (sq_done) begin
        mul_start = 1'b1;
        mul_a = 64'(sq_r);
        mul_b = MBW'(spm_q);
      end
      StDiff: begin
        dv_start = in_q.mode && fewer != '0;
        dv_n = 64'(base_q) * 64'(more);
        dv_d = fewer;
      end
      default: ;
    endcase
    if (st_q == StScXw && mul_done) begin
      dv_start = 1'b1;
      dv_n = 64'(mul_p[31:0]) << F;
    end
    if (st_q == StScYw && mul_done) begin
      dv_start = 1'b1;
      dv_n = 64'(mul_p[31:0]) << F;
    end
  end

  assign ctl.start = in_valid_i && in_ready_o;
  assign ctl.busy = st_q != StIdle;
  assign ctl.done = st_q == StOut;

  assign in_ready_o = st_q == StIdle;

  logic [31:0] slow;
  assign slow = (fewer == '0) ? IntervalMax :
                ((dv_q[63:32] != '0) ? IntervalMax : dv_q[31:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      span_q <= 16'd2000;
      left_q <= '0;
      top_q <= '0;
      height_q <= 16'd1000;
      extent_q <= 16'd1000;
      spm_q <= 32'd65536;
      base_q <= 16'd500;
      len_l_q <= '0;
      len_r_q <= '0;
      out_valid_q <= 1'b0;
      side_q <= 1'b0;
      sqphase_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (widx)
          RegSpan:   span_q <= pwdata[15:0];
          RegLeft:   left_q <= pwdata[15:0];
          RegTop:    top_q <= pwdata[15:0];
          RegHeight: height_q <= pwdata[15:0];
          RegExtent: extent_q <= pwdata[15:0];
          RegSteps:  spm_q <= pwdata;
          RegBase:   base_q <= pwdata[15:0];
          default: ;
        endcase
      end
      if (st_q == StOut && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (st_q)
        StIdle: if (ctl.start) st_q <= in_data_i.mode ? StScX : StOff;
        StScX:  st_q <= StScXw;
        StScXw: if (mul_done) st_q <= StScY;
        StScY:  if (dv_done) st_q <= StScYw;
        StScYw: if (mul_done) st_q <= StRoot;
        StOff:  st_q <= StSqH;
        StSqH:  if (mul_done) st_q <= StSqV;
        StSqV:  if (mul_done) st_q <= StRoot;
        StRoot: begin
          if (sqphase_q && dv_done) begin
            sqphase_q <= 1'b0;
            st_q <= StOff;
          end
          if (sq_done) st_q <= StLen;
        end
        StLen: if (mul_done) begin
          if (side_q) begin
            side_q <= 1'b0;
            st_q <= StDiff;
          end else begin
            side_q <= 1'b1;
            st_q <= StOff;
          end
        end
        StDiff: st_q <= (in_q.mode && fewer != '0) ? StDiv : StOut;
        StDiv:  if (dv_done) st_q <= StOut;
        StOut: if (!out_valid_q || out_ready_i) begin
          len_l_q <= nl_q;
          len_r_q <= nr_q;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
      if (st_q == StScYw && mul_done) sqphase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.start) begin
      in_q <= in_data_i;
      px_q <= {in_data_i.x_pos, F'(0)};
      py_q <= {in_data_i.y_pos, F'(0)};
    end
    if (st_q == StScY && dv_done) px_q <= px_n;
    if (st_q == StRoot && sqphase_q && dv_done) py_q <= px_n;
    if (st_q == StOff) v_q <= vv;
    if (st_q == StSqH && mul_done) hh_q <= (2*RW)'(mul_p);
    if (st_q == StLen && mul_done) begin
      if (side_q) nr_q <= len_sat;
      else nl_q <= len_sat;
    end
    if (st_q == StDiff) begin
      res_q.new_left_length <= nl_q;
      res_q.new_right_length <= nr_q;
      if (in_q.mode) begin
        res_q.left_steps <= ls[30:0];
        res_q.right_steps <= rs[30:0];
        res_q.left_pull <= dl[31];
        res_q.right_pull <= dr[31];
        res_q.left_interval_us <= l_more ? 32'(base_q) : IntervalMax;
        res_q.right_interval_us <= l_more ? IntervalMax : 32'(base_q);
      end else begin
        res_q.left_steps <= '0;
        res_q.right_steps <= '0;
        res_q.left_pull <= 1'b0;
        res_q.right_pull <= 1'b0;
        res_q.left_interval_us <= '0;
        res_q.right_interval_us <= '0;
      end
    end
    if (st_q == StDiv && dv_done) begin
      if (l_more) res_q.right_interval_us <= slow;
      else res_q.left_interval_us <= slow;
    end
    if (st_q == StOut && (!out_valid_q || out_ready_i)) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  `HPSP_ASSERT(a_ready_idle, clk_i, rst_ni, in_ready_o |-> !ctl.done)
  `HPSP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)
  `HPSP_ASSERT(a_busy_no_accept, clk_i, rst_ni, ctl.busy |-> !in_ready_o)
endmodule
`default_nettype wire

@@ rtl/hpsp_serial_mul.sv @@
// bit-serial unsigned multiplier, one multiplier bit per cycle
`default_nettype none
module hpsp_serial_mul import hpsp_pkg::*; #(
  parameter int unsigned AW = 64,
  parameter int unsigned BW = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [AW-1:0]    a_i,
  input  wire logic [BW-1:0]    b_i,
  output logic                  done_o,
  output logic [AW+BW-1:0]      p_o
);
  localparam int unsigned CW = $clog2(BW + 1);
  logic [AW+BW-1:0] acc_q, acc_d;
  logic [AW-1:0] a_q;
  logic [BW-1:0] b_q;
  logic [CW-1:0] cnt_q;
  logic run_q, done_q;
  logic [AW:0] top;

  always_comb begin
    top = {1'b0, acc_q[AW+BW-1:BW]} + (b_q[0] ? {1'b0, a_q} : '0);
    acc_d = {top, acc_q[BW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(BW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q <= a_i;
      b_q <= b_i;
    end else if (run_q) begin
      acc_q <= acc_d;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o = acc_q;
endmodule
`default_nettype wire

@@ rtl/hpsp_serial_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none
module hpsp_serial_div import hpsp_pkg::*; #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] n_i,
  input  wire logic [DW-1:0] d_i,
  output logic               done_o,
  output logic [NW-1:0]      q_o
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] q_q;
  logic [DW-1:0] r_q, d_q;
  logic [CW-1:0] cnt_q;
  logic run_q, done_q;
  logic [DW:0] sh, diff;

  always_comb begin
    sh = {r_q, q_q[NW-1]};
    diff = sh - {1'b0, d_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(NW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= n_i;
      r_q <= '0;
      d_q <= d_i;
    end else if (run_q) begin
      if (!diff[DW]) begin
        r_q <= diff[DW-1:0];
        q_q <= {q_q[NW-2:0], 1'b1};
      end else begin
        r_q <= sh[DW-1:0];
        q_q <= {q_q[NW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign q_o = q_q;
endmodule
`default_nettype wire

@@ rtl/hpsp_serial_sqrt.sv @@
// digit-by-digit integer square root, one result bit per cycle
`default_nettype none
module hpsp_serial_sqrt import hpsp_pkg::*; #(
  parameter int unsigned RW = 33
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [2*RW-1:0] n_i,
  output logic                 done_o,
  output logic [RW-1:0]        r_o
);
  localparam int unsigned CW = $clog2(RW + 1);
  logic [2*RW-1:0] n_q;
  logic [RW+1:0] rem_q, trial, sh;
  logic [RW-1:0] r_q;
  logic [CW-1:0] cnt_q;
  logic run_q, done_q;

  always_comb begin
    sh = {rem_q[RW-1:0], n_q[2*RW-1:2*RW-2]};
    trial = sh - {r_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(RW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= n_i;
      rem_q <= '0;
      r_q <= '0;
    end else if (run_q) begin
      n_q <= n_q << 2;
      if (!trial[RW+1]) begin
        rem_q <= trial;
        r_q <= {r_q[RW-2:0], 1'b1};
      end else begin
        rem_q <= sh;
        r_q <= {r_q[RW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign r_o = r_q;
endmodule
`default_nettype wire

@@ tb/hanging_plotter_segment_planner_unit_tb.sv @@
// testbench for the segment planner: random and directed targets checked against a behavioral model
`timescale 1ns / 1ps
module hanging_plotter_segment_planner_unit_tb;
  import hpsp_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DrainCycles = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_beat_t out_data_o;

  hanging_plotter_segment_planner_unit uut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // plotter geometry and current belt state held by the model
  logic [15:0] span_mm, left_mm, top_mm, height_mm, extent_mm, base_us;
  logic [31:0] steps_q16;
  logic [30:0] left_len, right_len;

  in_beat_t target_q[$];
  out_beat_t plan_q[$];
  int unsigned mismatches = 0;
  int unsigned stray = 0;
  int unsigned hold_cycles = 0;
  bit stim_done = 1'b0;

  function automatic logic [30:0] belt_steps(logic signed [63:0] h, logic signed [63:0] v);
    logic [127:0] norm;
    logic [127:0] root;
    logic [127:0] cand;
    logic [127:0] prod;
    logic [63:0] hm, vm;
    hm = h < 0 ? -h : h;
    vm = v < 0 ? -v : v;
    norm = 128'(hm) * hm + 128'(vm) * vm;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= norm) root = cand;
    end
    prod = (root * steps_q16) >> (FracBits + 16);
    return prod > 128'(LenMax) ? LenMax : prod[30:0];
  endfunction

  function automatic logic [31:0] slow_rate(logic [30:0] more, logic [30:0] fewer);
    logic [63:0] t;
    if (fewer == 0) return IntervalMax;
    t = 64'(base_us) * more / fewer;
    return t > 64'(IntervalMax) ? IntervalMax : t[31:0];
  endfunction

  function automatic out_beat_t plan_segment(in_beat_t t);
    out_beat_t r;
    logic [63:0] px, py;
    logic signed [63:0] hl, hr, v, dl, dr;
    logic [30:0] nl, nr;
    if (t.mode) begin
      px = ((64'(t.x_pos) * extent_mm) << FracBits) / CoordFull;
      py = ((64'(t.y_pos) * extent_mm) << FracBits) / CoordFull;
    end else begin
      px = 64'(t.x_pos) << FracBits;
      py = 64'(t.y_pos) << FracBits;
    end
    hl = (64'(left_mm) << FracBits) + px;
    hr = (64'(span_mm) << FracBits) - (64'(left_mm) << FracBits) - px;
    v = ((64'(top_mm) + height_mm) << FracBits) - py;
    nl = belt_steps(hl, v);
    nr = belt_steps(hr, v);
    r = '0;
    if (t.mode) begin
      dl = 64'(nl) - 64'(left_len);
      dr = 64'(nr) - 64'(right_len);
      r.left_pull = dl < 0;
      r.right_pull = dr < 0;
      r.left_steps = dl < 0 ? 31'(-dl) : 31'(dl);
      r.right_steps = dr < 0 ? 31'(-dr) : 31'(dr);
      if (r.left_steps > r.right_steps) begin
        r.left_interval_us = 32'(base_us);
        r.right_interval_us = slow_rate(r.left_steps, r.right_steps);
      end else begin
        r.right_interval_us = 32'(base_us);
        r.left_interval_us = slow_rate(r.right_steps, r.left_steps);
      end
    end
    r.new_left_length = nl;
    r.new_right_length = nr;
    left_len = nl;
    right_len = nr;
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegSpan: span_mm = val[15:0];
      RegLeft: left_mm = val[15:0];
      RegTop: top_mm = val[15:0];
      RegHeight: height_mm = val[15:0];
      RegExtent: extent_mm = val[15:0];
      RegSteps: steps_q16 = val;
      RegBase: base_us = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (target_q.size() != 0 || plan_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic push_target(logic mode, logic [15:0] x, logic [15:0] y);
    in_beat_t t;
    t.mode = mode;
    t.x_pos = x;
    t.y_pos = y;
    target_q.push_back(t);
  endtask

  // driver
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        plan_q.push_back(plan_segment(in_data_i));
        void'(target_q.pop_front());
        send_gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (target_q.size() != 0 && !(in_valid_i && in_ready_o && target_q.size() == 0))
        begin
          in_valid_i <= 1'b1;
          in_data_i <= target_q[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  int unsigned recv_gap = 0;
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (plan_q.size() == 0) begin
          stray++;
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", out_data_o);
        end else begin
          want = plan_q.pop_front();
          if (out_data_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", want, out_data_o);
          end
        end
        recv_gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic random_batch(int unsigned n);
    logic [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: begin x = '0; y = '1; end
        1: begin x = 16'($urandom); y = {$urandom_range(0, 1) ? 16'hffff : 16'h0}; end
        default: begin x = 16'($urandom); y = 16'($urandom); end
      endcase
      push_target($urandom_range(0, 7) != 0, x, y);
    end
  endtask

  initial begin
    span_mm = 2000; left_mm = 0; top_mm = 0; height_mm = 1000;
    extent_mm = 1000; steps_q16 = 65536; base_us = 500;
    left_len = '0; right_len = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    // directed targets at reset geometry
    push_target(1'b1, 16'd0, 16'd0);
    push_target(1'b1, 16'd0, 16'd0);
    push_target(1'b1, 16'hffff, 16'hffff);
    push_target(1'b1, 16'h8000, 16'h0000);
    push_target(1'b0, 16'd1000, 16'd500);
    push_target(1'b1, 16'hffff, 16'h0000);
    push_target(1'b0, 16'hffff, 16'hffff);
    push_target(1'b1, 16'h0000, 16'hffff);
    push_target(1'b1, 16'h7fff, 16'h7fff);
    push_target(1'b0, 16'd0, 16'd0);
    wait_idle();
    // extreme geometry: huge lengths saturate, tiny base interval
    write_reg(RegSteps, 32'hffffffff);
    write_reg(RegSpan, 16'hffff);
    write_reg(RegTop, 16'hffff);
    write_reg(RegHeight, 16'hffff);
    write_reg(RegExtent, 16'hffff);
    write_reg(RegBase, 16'd1);
    push_target(1'b1, 16'hffff, 16'h0000);
    push_target(1'b1, 16'h0000, 16'hffff);
    push_target(1'b0, 16'h0000, 16'h0000);
    wait_idle();
    // sheet outside the anchors, negative offsets, large base interval
    write_reg(RegSteps, 32'd1);
    write_reg(RegLeft, 16'hffff);
    write_reg(RegSpan, 16'd0);
    write_reg(RegTop, 16'd0);
    write_reg(RegHeight, 16'd0);
    write_reg(RegBase, 16'hffff);
    write_reg(RegExtent, 16'd1);
    push_target(1'b1, 16'hffff, 16'hffff);
    push_target(1'b0, 16'h1234, 16'hffff);
    wait_idle();
    // realistic geometry with fine stepping
    write_reg(RegSteps, 32'd80 << 16);
    write_reg(RegSpan, 16'd1200);
    write_reg(RegLeft, 16'd200);
    write_reg(RegTop, 16'd150);
    write_reg(RegHeight, 16'd600);
    write_reg(RegExtent, 16'd800);
    write_reg(RegBase, 16'd300);
    random_batch(400);
    // receiver holds off while targets keep coming
    hold_cycles = 4000;
    wait_idle();
    write_reg(RegSteps, $urandom_range(1, 32'h00ffffff));
    write_reg(RegSpan, $urandom);
    write_reg(RegLeft, $urandom);
    write_reg(RegTop, $urandom);
    write_reg(RegHeight, $urandom);
    write_reg(RegExtent, $urandom_range(1, 65535));
    write_reg(RegBase, $urandom_range(1, 65535));
    random_batch(400);
    wait_idle();
    write_reg(RegSteps, $urandom);
    write_reg(RegSpan, $urandom);
    write_reg(RegLeft, $urandom);
    write_reg(RegTop, $urandom);
    write_reg(RegHeight, $urandom);
    write_reg(RegExtent, $urandom);
    write_reg(RegBase, $urandom);
    random_batch(425);
    while (target_q.size() != 0 || plan_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && stray == 0 && plan_q.size() == 0) begin
      $display("hanging_plotter_segment_planner_unit_tb: PASS");
    end else begin
      $display("hanging_plotter_segment_planner_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("hanging_plotter_segment_planner_unit_tb: FAIL");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/hpsp_pkg.sv
rtl/hpsp_serial_mul.sv
rtl/hpsp_serial_div.sv
rtl/hpsp_serial_sqrt.sv
rtl/hanging_plotter_segment_planner_unit.sv
tb/hanging_plotter_segment_planner_unit_tb.sv
